>>> src/cdo_pkg.sv
package cdo_pkg;

	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int COUNT_W = 16;
	localparam int DELTA_W = 18;

	localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

	// Exact floor(y / 100) for every 14-bit year: (y * 5243) >> 19.
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int DIV100_SHIFT = 19;
	localparam int PROD_W = 27;
	localparam int CENT_W = 8;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0] DAYS_DEC = 5'd31;
	localparam logic [DAY_W-1:0] DAYS_LEAP_FEB = 5'd29;

	localparam logic [DAY_W-1:0] MONTH_LEN [13] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_ADD  = 2'd1,
		REQ_SUB  = 2'd2,
		REQ_CMP  = 2'd3
	} req_type_t;

	typedef struct packed {
		req_type_t req_type;
		logic [YEAR_W-1:0] year_in;
		logic [MONTH_W-1:0] month_in;
		logic [COUNT_W-1:0] day_value;
	} cdo_req_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year_out;
		logic [MONTH_W-1:0] month_out;
		logic [DAY_W-1:0] day_out;
		logic error;
		logic is_earlier;
		logic is_later;
	} cdo_rsp_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic step;
		logic emit;
	} cdo_cmd_t;

	typedef struct packed {
		logic is_move;
		logic have_date;
		logic fin;
	} cdo_sts_t;

	function automatic logic [DAY_W-1:0] days_in(logic [MONTH_W-1:0] m, logic leap);
		logic [DAY_W-1:0] d;
		if (m == 4'd0 || m > MONTH_DEC) begin
			d = '0;
		end else if (m == MONTH_FEB && leap) begin
			d = DAYS_LEAP_FEB;
		end else begin
			d = MONTH_LEN[m];
		end
		return d;
	endfunction

endpackage

>>> src/cdo_ctrl.sv
module cdo_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  cdo_pkg::cdo_sts_t sts,
	output cdo_pkg::cdo_cmd_t cmd
);
	import cdo_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_EXEC,
		S_STEP,
		S_DONE
	} state_t;

	state_t state_q;
	logic rsp_valid_q;
	logic slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.latch = req_valid;
			S_EXEC: cmd.exec = 1'b1;
			S_STEP: cmd.step = 1'b1;
			S_DONE: cmd.emit = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: state_q <= S_EXEC;
				S_EXEC: begin
					if (sts.is_move && sts.have_date) begin
						state_q <= S_STEP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_STEP: begin
					if (sts.fin) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> src/cdo_dp.sv
module cdo_dp (
	input  logic clk,
	input  logic arst_n,
	input  cdo_pkg::cdo_req_t req,
	input  cdo_pkg::cdo_cmd_t cmd,
	output cdo_pkg::cdo_sts_t sts,
	output cdo_pkg::cdo_rsp_t rsp
);
	import cdo_pkg::*;

	logic [YEAR_W-1:0] cur_year_q;
	logic [MONTH_W-1:0] cur_month_q;
	logic [DAY_W-1:0] cur_day_q;

	req_type_t req_type_q;
	logic [MONTH_W-1:0] month_in_q;
	logic [COUNT_W-1:0] day_value_q;
	logic [YEAR_W-1:0] wy_q;
	logic [MONTH_W-1:0] wm_q;
	logic signed [DELTA_W-1:0] d_q;
	logic err_q;
	logic earlier_q;
	logic later_q;
	cdo_rsp_t rsp_q;
	logic [PROD_W-1:0] prod_s1;

	logic [CENT_W-1:0] cent;
	logic [YEAR_W:0] cent100;
	logic leap;
	logic [DAY_W-1:0] dim;
	logic [DAY_W-1:0] dim_prev;
	logic signed [DELTA_W-1:0] dim_ext;
	logic fwd;
	logic done;
	logic fail;
	logic have_date;
	logic load_ok;
	logic earlier;
	logic same;
	logic [MONTH_W-1:0] wm_prev;

	// The quotient by 100 is registered from the working year, so it trails it; February
	// is never reached before the quotient has caught up after a year change.
	assign cent = prod_s1[PROD_W-1:DIV100_SHIFT];
	assign cent100 = (YEAR_W+1)'(cent * 7'd100);
	assign leap = (cent100 == {1'b0, wy_q}) ? (cent[1:0] == 2'b00) : (wy_q[1:0] == 2'b00);

	assign fwd = (req_type_q == REQ_ADD);
	assign dim = days_in(wm_q, leap);
	assign dim_ext = $signed({{(DELTA_W-DAY_W){1'b0}}, dim});
	assign wm_prev = wm_q - 4'd1;
	assign dim_prev = days_in(wm_prev, leap);
	assign done = fwd ? !(d_q > dim_ext) : (d_q > 0);
	assign fail = !done && (fwd ? (wm_q == MONTH_DEC && wy_q == MAX_YEAR)
	                            : (wm_q == MONTH_JAN && wy_q == YEAR_W'(1)));

	assign have_date = cur_year_q >= YEAR_W'(1) && cur_year_q <= MAX_YEAR &&
	                   cur_month_q >= MONTH_JAN && cur_month_q <= MONTH_DEC &&
	                   cur_day_q >= DAY_W'(1) && cur_day_q <= days_in(cur_month_q, leap);

	assign load_ok = wy_q >= YEAR_W'(1) && wy_q <= MAX_YEAR &&
	                 month_in_q >= MONTH_JAN && month_in_q <= MONTH_DEC &&
	                 day_value_q >= COUNT_W'(1) &&
	                 day_value_q <= {{(COUNT_W-DAY_W){1'b0}}, days_in(month_in_q, leap)};

	assign same = cur_year_q == wy_q && cur_month_q == month_in_q &&
	              {{(COUNT_W-DAY_W){1'b0}}, cur_day_q} == day_value_q;

	always_comb begin
		if (cur_year_q != wy_q) begin
			earlier = cur_year_q < wy_q;
		end else if (cur_month_q != month_in_q) begin
			earlier = cur_month_q < month_in_q;
		end else begin
			earlier = {{(COUNT_W-DAY_W){1'b0}}, cur_day_q} < day_value_q;
		end
	end

	assign sts.is_move = (req_type_q == REQ_ADD) || (req_type_q == REQ_SUB);
	assign sts.have_date = have_date;
	assign sts.fin = done || fail;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q <= '0;
			cur_month_q <= '0;
			cur_day_q <= '0;
		end else if (cmd.exec && req_type_q == REQ_LOAD) begin
			if (load_ok) begin
				cur_year_q <= wy_q;
				cur_month_q <= month_in_q;
				cur_day_q <= day_value_q[DAY_W-1:0];
			end else begin
				cur_year_q <= '0;
				cur_month_q <= '0;
				cur_day_q <= '0;
			end
		end else if (cmd.step && done) begin
			cur_year_q <= wy_q;
			cur_month_q <= wm_q;
			cur_day_q <= d_q[DAY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(wy_q * DIV100_MUL);
		if (cmd.latch) begin
			req_type_q <= req.req_type;
			month_in_q <= req.month_in;
			day_value_q <= req.day_value;
			wy_q <= (req.req_type == REQ_LOAD || req.req_type == REQ_CMP) ? req.year_in
			                                                              : cur_year_q;
			wm_q <= cur_month_q;
			err_q <= 1'b0;
			earlier_q <= 1'b0;
			later_q <= 1'b0;
		end
		if (cmd.exec) begin
			case (req_type_q)
				REQ_LOAD: err_q <= !load_ok;
				REQ_CMP: begin
					earlier_q <= earlier;
					later_q <= !earlier && !same;
				end
				REQ_ADD, REQ_SUB: begin
					if (!have_date) begin
						err_q <= 1'b1;
					end else if (fwd) begin
						d_q <= $signed({{(DELTA_W-DAY_W){1'b0}}, cur_day_q}) +
						       $signed({{(DELTA_W-COUNT_W){1'b0}}, day_value_q});
					end else begin
						d_q <= $signed({{(DELTA_W-DAY_W){1'b0}}, cur_day_q}) -
						       $signed({{(DELTA_W-COUNT_W){1'b0}}, day_value_q});
					end
				end
				default: err_q <= 1'b0;
			endcase
		end
		if (cmd.step && !done) begin
			if (fail) begin
				err_q <= 1'b1;
			end else if (fwd) begin
				d_q <= d_q - dim_ext;
				if (wm_q == MONTH_DEC) begin
					wm_q <= MONTH_JAN;
					wy_q <= wy_q + YEAR_W'(1);
				end else begin
					wm_q <= wm_q + 4'd1;
				end
			end else begin
				if (wm_q == MONTH_JAN) begin
					wm_q <= MONTH_DEC;
					wy_q <= wy_q - YEAR_W'(1);
					d_q <= d_q + $signed({{(DELTA_W-DAY_W){1'b0}}, DAYS_DEC});
				end else begin
					wm_q <= wm_prev;
					d_q <= d_q + $signed({{(DELTA_W-DAY_W){1'b0}}, dim_prev});
				end
			end
		end
		if (cmd.emit) begin
			rsp_q.year_out <= cur_year_q;
			rsp_q.month_out <= cur_month_q;
			rsp_q.day_out <= cur_day_q;
			rsp_q.error <= err_q;
			rsp_q.is_earlier <= earlier_q;
			rsp_q.is_later <= later_q;
		end
	end

endmodule

>>> src/calendar_date_offset_top.sv
// Gregorian date register with add, subtract, load and compare requests.
// A request word enters on req/req_valid/req_ready and is accepted when
// valid and ready are both high. Exactly one response word leaves on
// rsp/rsp_valid/rsp_ready for every request, in order.
// Load and compare pass from acceptance through a prepare, an execute and a
// done state back to idle; the response becomes valid as the done state is left.
// An add or subtract with no valid stored date is refused along the same path.
// Otherwise add and subtract step one month per cycle in the datapath, in a step
// state between execute and done, until the day falls inside the month or the
// year range runs out.
// Only one request is in flight at a time; req_ready is high while the
// controller is idle, even while an earlier response still waits.
// A stalled response is held in the output register, and the next request
// finishes its work and then waits until that register is taken.
// Reset clears the stored date to zeros (no valid date), drops rsp_valid
// and leaves the block ready for a request.
module calendar_date_offset_top (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  cdo_pkg::cdo_req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cdo_pkg::cdo_rsp_t rsp
);
	import cdo_pkg::*;

	cdo_cmd_t cmd;
	cdo_sts_t sts;

	cdo_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.sts(sts),
		.cmd(cmd)
	);

	cdo_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd(cmd),
		.sts(sts),
		.rsp(rsp)
	);

endmodule

>>> src/cdo_checker.sv
module cdo_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input cdo_pkg::cdo_req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input cdo_pkg::cdo_rsp_t rsp
);
	import cdo_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in flight");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.is_earlier && rsp.is_later) &&
		              !(rsp.error && (rsp.is_earlier || rsp.is_later)))
		else $error("inconsistent response flags");

	a_date_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.month_out == '0) == (rsp.year_out == '0)) &&
		              ((rsp.day_out == '0) == (rsp.year_out == '0)))
		else $error("partially cleared date in response");

endmodule

bind calendar_date_offset_top cdo_checker u_cdo_checker (.*);

>>> verif/date_response_checker.sv
`timescale 1ns / 1ps

module date_response_checker
	import cdo_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  cdo_req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  cdo_rsp_t rsp,
	output int mismatch_count,
	output int rsp_outstanding
);

	cdo_rsp_t expected_dates[$];
	logic [YEAR_W-1:0] held_year;
	logic [MONTH_W-1:0] held_month;
	logic [DAY_W-1:0] held_day;
	cdo_rsp_t want;
	int fails;
	int bad;

	function automatic int month_length(int y, int m);
		bit leap_year;
		leap_year = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
		if (m < 1 || m > 12)
			return 0;
		if (m == 2)
			return leap_year ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic bit date_ok(int y, int m, int d);
		return y >= 1 && y <= int'(MAX_YEAR) && m >= 1 && m <= 12 &&
			d >= 1 && d <= month_length(y, m);
	endfunction

	// Applies one request word to the held date and returns the response it must produce.
	function automatic cdo_rsp_t predict_date_rsp(cdo_req_t w);
		cdo_rsp_t r;
		int y;
		int m;
		int d;
		bit out_of_range;
		r = '0;
		y = held_year;
		m = held_month;
		d = held_day;
		out_of_range = 1'b0;
		case (w.req_type)
			REQ_LOAD: begin
				if (date_ok(w.year_in, w.month_in, w.day_value)) begin
					y = w.year_in;
					m = w.month_in;
					d = w.day_value;
				end else begin
					y = 0;
					m = 0;
					d = 0;
					r.error = 1'b1;
				end
			end
			REQ_ADD: begin
				if (!date_ok(y, m, d)) begin
					r.error = 1'b1;
				end else begin
					d += w.day_value;
					while (!out_of_range && d > month_length(y, m)) begin
						d -= month_length(y, m);
						m++;
						if (m > 12) begin
							m = 1;
							y++;
							out_of_range = y > int'(MAX_YEAR);
						end
					end
				end
			end
			REQ_SUB: begin
				if (!date_ok(y, m, d)) begin
					r.error = 1'b1;
				end else begin
					d -= w.day_value;
					while (!out_of_range && d <= 0) begin
						m--;
						if (m == 0) begin
							m = 12;
							y--;
							out_of_range = y < 1;
						end
						if (!out_of_range)
							d += month_length(y, m);
					end
				end
			end
			default: begin
				if (y != w.year_in)
					r.is_earlier = y < w.year_in;
				else if (m != w.month_in)
					r.is_earlier = m < w.month_in;
				else
					r.is_earlier = d < w.day_value;
				r.is_later = !r.is_earlier &&
					!(y == w.year_in && m == w.month_in && d == w.day_value);
			end
		endcase
		if (out_of_range) begin
			r.error = 1'b1;
		end else begin
			held_year = y[YEAR_W-1:0];
			held_month = m[MONTH_W-1:0];
			held_day = d[DAY_W-1:0];
		end
		r.year_out = held_year;
		r.month_out = held_month;
		r.day_out = held_day;
		return r;
	endfunction

	function automatic int field_differs(string name, int exp_val, int act_val);
		if (exp_val == act_val)
			return 0;
		if (fails < 40)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
				act_val);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_year = '0;
			held_month = '0;
			held_day = '0;
			expected_dates.delete();
			fails = 0;
			mismatch_count <= 0;
			rsp_outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_dates.size() == 0) begin
					if (fails < 40)
						$display("%0t: unexpected word, expected none, actual %0d-%0d-%0d",
							$time, rsp.year_out, rsp.month_out, rsp.day_out);
					fails++;
				end else begin
					want = expected_dates.pop_front();
					bad = 0;
					bad += field_differs("year_out", want.year_out, rsp.year_out);
					bad += field_differs("month_out", want.month_out, rsp.month_out);
					bad += field_differs("day_out", want.day_out, rsp.day_out);
					bad += field_differs("error", want.error, rsp.error);
					bad += field_differs("is_earlier", want.is_earlier, rsp.is_earlier);
					bad += field_differs("is_later", want.is_later, rsp.is_later);
					if (bad != 0)
						fails++;
				end
			end
			if (req_valid && req_ready)
				expected_dates.push_back(predict_date_rsp(req));
			mismatch_count <= fails;
			rsp_outstanding <= expected_dates.size();
		end
	end

endmodule

>>> verif/tb_calendar_date_offset_top.sv
`timescale 1ns / 1ps

module tb_calendar_date_offset_top;
	import cdo_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	cdo_req_t req;
	logic rsp_valid;
	logic rsp_ready;
	cdo_rsp_t rsp;

	int mismatch_count;
	int rsp_outstanding;
	int tx_idle_pct = 9;
	int rx_idle_pct = 50;
	bit hold_rsp_go = 1'b0;
	int words_sent = 0;
	int op_count [4] = '{0, 0, 0, 0};
	int cur_y;
	int cur_m;
	int cur_d;

	calendar_date_offset_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	date_response_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.mismatch_count(mismatch_count),
		.rsp_outstanding(rsp_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// The receiver; a hold-off request parks it for a long stretch of cycles.
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp_go) begin
				hold_left = 400;
				hold_rsp_go = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= $urandom_range(99) >= rx_idle_pct;
			end
		end
	end

	function automatic cdo_req_t make_word(req_type_t op, int y, int m, int d);
		cdo_req_t w;
		w.req_type = op;
		w.year_in = y[YEAR_W-1:0];
		w.month_in = m[MONTH_W-1:0];
		w.day_value = d[COUNT_W-1:0];
		return w;
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(9);
		if (r < 6)
			return $urandom_range(60);
		if (r < 8)
			return $urandom_range(1500, 61);
		if (r < 9)
			return $urandom_range(9000, 1501);
		return $urandom_range(65535);
	endfunction

	function automatic cdo_req_t near_compare();
		int y;
		int m;
		int d;
		y = cur_y;
		m = cur_m;
		d = cur_d;
		case ($urandom_range(6))
			0: y++;
			1: y--;
			2: m++;
			3: m--;
			4: d++;
			5: d--;
			default: ;
		endcase
		return make_word(REQ_CMP, y, m, d);
	endfunction

	function automatic cdo_req_t random_move();
		case ($urandom_range(4))
			0, 1: return make_word(REQ_ADD, $urandom, $urandom, pick_count());
			2, 3: return make_word(REQ_SUB, $urandom, $urandom, pick_count());
			default: return near_compare();
		endcase
	endfunction

	task automatic send_word(input cdo_req_t w);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		words_sent++;
		op_count[w.req_type]++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		@(posedge clk);
		while (rsp_outstanding != 0)
			@(posedge clk);
	endtask

	// Years near both ends of the range and month-end days are favored.
	task automatic load_random_date();
		int r;
		bit leap_year;
		r = $urandom_range(9);
		if (r == 0)
			cur_y = $urandom_range(3, 1);
		else if (r == 1)
			cur_y = $urandom_range(9999, 9997);
		else
			cur_y = $urandom_range(9999, 1);
		cur_m = $urandom_range(12, 1);
		leap_year = (cur_y % 4 == 0 && cur_y % 100 != 0) || cur_y % 400 == 0;
		cur_d = days_in(cur_m[MONTH_W-1:0], leap_year);
		if ($urandom_range(9) >= 3)
			cur_d = $urandom_range(cur_d, 1);
		send_word(make_word(REQ_LOAD, cur_y, cur_m, cur_d));
	endtask

	task automatic run_random(input int n);
		int stop;
		int c;
		int kind;
		stop = words_sent + n;
		while (words_sent < stop) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				load_random_date();
				c = pick_count();
				send_word(make_word(REQ_ADD, $urandom, $urandom, c));
				send_word(make_word(REQ_SUB, $urandom, $urandom, c));
				send_word(make_word(REQ_CMP, cur_y, cur_m, cur_d));
			end else if (kind < 55) begin
				load_random_date();
				repeat ($urandom_range(4, 1))
					send_word(random_move());
			end else if (kind < 85) begin
				send_word(random_move());
			end else begin
				send_word(make_word(req_type_t'($urandom_range(3)), $urandom, $urandom,
					$urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_word(make_word(REQ_ADD, 0, 0, 5));
		send_word(make_word(REQ_SUB, 0, 0, 5));
		send_word(make_word(REQ_CMP, 0, 0, 0));
		send_word(make_word(REQ_LOAD, 0, 1, 1));
		send_word(make_word(REQ_LOAD, 16383, 15, 65535));
		send_word(make_word(REQ_LOAD, 2023, 0, 1));
		send_word(make_word(REQ_LOAD, 2023, 13, 1));
		send_word(make_word(REQ_LOAD, 1900, 2, 29));
		send_word(make_word(REQ_LOAD, 2023, 4, 31));
		send_word(make_word(REQ_ADD, 0, 0, 1));
		send_word(make_word(REQ_LOAD, 2000, 2, 29));
		send_word(make_word(REQ_ADD, 0, 0, 0));
		send_word(make_word(REQ_SUB, 0, 0, 0));
		send_word(make_word(REQ_ADD, 0, 0, 366));
		send_word(make_word(REQ_CMP, 2001, 3, 1));
		send_word(make_word(REQ_CMP, 2001, 3, 2));
		send_word(make_word(REQ_CMP, 2001, 2, 28));
		send_word(make_word(REQ_LOAD, 2024, 1, 31));
		send_word(make_word(REQ_SUB, 0, 0, 31));
		send_word(make_word(REQ_LOAD, 9999, 12, 31));
		send_word(make_word(REQ_ADD, 0, 0, 1));
		send_word(make_word(REQ_SUB, 0, 0, 65535));
		send_word(make_word(REQ_LOAD, 1, 1, 1));
		send_word(make_word(REQ_SUB, 0, 0, 1));
		send_word(make_word(REQ_ADD, 0, 0, 65535));
		send_word(make_word(REQ_CMP, 16383, 15, 65535));
		drain_results();

		run_random(82);
		drain_results();

		tx_idle_pct = 50;
		rx_idle_pct = 9;
		hold_rsp_go = 1'b1;
		run_random(82);
		drain_results();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(82);
		drain_results();
		repeat (20)
			@(posedge clk);

		$display("Sent %0d words: %0d loads, %0d adds, %0d subtracts, %0d compares.",
			words_sent, op_count[REQ_LOAD], op_count[REQ_ADD], op_count[REQ_SUB],
			op_count[REQ_CMP]);
		$display("Traffic ran with idling on each side in turn, a long response %s",
			"stall and drained pauses.");
		if (mismatch_count == 0 && rsp_outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> calendar_date_offset_top.f
src/cdo_pkg.sv
src/cdo_ctrl.sv
src/cdo_dp.sv
src/calendar_date_offset_top.sv
src/cdo_checker.sv
verif/date_response_checker.sv
verif/tb_calendar_date_offset_top.sv
